// ----- rtl/core/ntab_pkg.sv -----
// ----------------------------------------------------------------------------
// ntab_pkg
// Shared types and constants of the nested context table.
// ----------------------------------------------------------------------------
package ntab_pkg;

    localparam int NUM_ENTRIES     = 8;
    localparam int USER_COUNT_BITS = 8;
    localparam int IDX_W           = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int KEY_W           = 64;
    localparam int VMID_SHIFT      = 48;
    localparam int VMID_MAX_WIDTH  = 16;
    localparam int VMID_CFG_W      = 5;

    localparam logic [USER_COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [3:0]                 HOST_INDEX = 4'(NUM_ENTRIES);
    localparam logic [VMID_CFG_W-1:0]      VMID_WIDTH_RESET = 5'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUT  = 1'b1;

    // Request item.
    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] base_value;
        logic             nested_enable;
        logic             hyp_context;
        logic [3:0]       held_entry;
    } t_req;

    // Result item.
    typedef struct packed {
        logic [3:0] entry_index;
        logic       hit;
        logic       cleanup_needed;
        logic       table_full;
    } t_rsp;

    // One table entry as stored in memory (key bit 0 is always clear, not kept).
    typedef struct packed {
        logic [KEY_W-1:1]           key;
        logic                       nested;
        logic [USER_COUNT_BITS-1:0] users;
    } t_entry;

endpackage

// ----- rtl/core/nested_context_table.sv -----
// ----------------------------------------------------------------------------
// nested_context_table
// Operation: a put of the host or beyond the table, or a hypervisor load, gives
// its result in the cycle after start; a put of a table entry reads the entry,
// goes through S_PUT and gives its result. A table load walks the entries in
// order and gives its result after the compare of the entry that hits, or after
// the last entry on a miss or a full table.
// Items: one at a time; busy holds off start while a table walk or the put
// of a table entry runs, and the next item may start in the cycle that shows
// the result. Results cannot be stalled.
// Reset: synchronous, active low; clears valid bits and control, sets
// vmid_width to 8.
// ----------------------------------------------------------------------------
module nested_context_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ntab_pkg::t_req                i_req,
    output logic                          o_done,
    output ntab_pkg::t_rsp                o_result,
    input  logic                          i_cfg_we,
    input  logic [ntab_pkg::VMID_CFG_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUT
    } t_state;

    localparam logic [ntab_pkg::IDX_W-1:0] LAST_IDX =
        ntab_pkg::IDX_W'(ntab_pkg::NUM_ENTRIES - 1);

    t_state                          r_state;
    ntab_pkg::t_req                  r_req;
    logic [ntab_pkg::VMID_CFG_W-1:0] r_vmid_width;
    logic [ntab_pkg::NUM_ENTRIES-1:0] r_valid;     // entry has been used before
    logic [ntab_pkg::IDX_W-1:0]      r_cmp_idx;   // index of entry in r_rd_data
    logic                            r_free_found;
    logic [ntab_pkg::IDX_W-1:0]      r_free_idx;
    logic                            r_free_clean;
    logic                            r_done;
    logic                            n_done;
    ntab_pkg::t_rsp                  r_result;

    // Entry memory: one read port with registered data, one write port.
    ntab_pkg::t_entry                mem [ntab_pkg::NUM_ENTRIES];
    ntab_pkg::t_entry                r_rd_data;
    logic                            mem_rd_en;
    logic [ntab_pkg::IDX_W-1:0]      mem_rd_addr;
    logic                            mem_wr_en;
    logic [ntab_pkg::IDX_W-1:0]      mem_wr_addr;
    ntab_pkg::t_entry                mem_wr_data;

    // Compare logic for the entry currently on the read data.
    logic [ntab_pkg::VMID_CFG_W-1:0] vmid_w;
    logic [ntab_pkg::VMID_MAX_WIDTH-1:0] vmid_mask;
    logic [ntab_pkg::VMID_MAX_WIDTH-1:0] vmid_req;
    logic [ntab_pkg::VMID_MAX_WIDTH-1:0] vmid_ent;
    logic                            cur_valid;
    logic                            cur_match;
    logic                            cur_free;
    logic                            put_in_range;
    logic [ntab_pkg::IDX_W-1:0]      held_idx;
    logic                            claim_ok;
    logic [ntab_pkg::IDX_W-1:0]      claim_idx;
    logic                            claim_clean;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    assign held_idx     = ntab_pkg::IDX_W'(r_req.held_entry);
    assign put_in_range = (i_req.held_entry < ntab_pkg::HOST_INDEX);

    // VMID field: bits from 48 upward, width clamped to 16.
    always_comb begin
        vmid_w    = (r_vmid_width > ntab_pkg::VMID_CFG_W'(ntab_pkg::VMID_MAX_WIDTH))
                    ? ntab_pkg::VMID_CFG_W'(ntab_pkg::VMID_MAX_WIDTH) : r_vmid_width;
        vmid_mask = ntab_pkg::VMID_MAX_WIDTH'((17'd1 << vmid_w) - 17'd1);
        vmid_req  = r_req.base_value[ntab_pkg::KEY_W-1:ntab_pkg::VMID_SHIFT] & vmid_mask;
        vmid_ent  = r_rd_data.key[ntab_pkg::KEY_W-1:ntab_pkg::VMID_SHIFT] & vmid_mask;
    end

    // Match and free test; an entry never used is free and never matches.
    always_comb begin
        cur_valid = r_valid[r_cmp_idx];
        if (r_req.nested_enable) begin
            cur_match = cur_valid && r_rd_data.nested &&
                        (r_rd_data.key == r_req.base_value[ntab_pkg::KEY_W-1:1]);
        end else begin
            cur_match = cur_valid && !r_rd_data.nested && (vmid_ent == vmid_req);
        end
        cur_free = !cur_valid || (r_rd_data.users == '0);

        // First free entry, counting the one on the read data now.
        if (r_free_found) begin
            claim_ok    = 1'b1;
            claim_idx   = r_free_idx;
            claim_clean = r_free_clean;
        end else begin
            claim_ok    = cur_free;
            claim_idx   = r_cmp_idx;
            claim_clean = cur_valid;
        end
    end

    // Result strobe for the next cycle.
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                // Host or out-of-range put and hypervisor load answer at once.
                n_done = start && ((i_req.operation == ntab_pkg::OP_PUT)
                                   ? !put_in_range : i_req.hyp_context);
            end
            S_SCAN: begin
                n_done = cur_match || (r_cmp_idx == LAST_IDX);
            end
            S_PUT: begin
                n_done = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_cmp_idx;
        mem_wr_data = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                // Read entry 0 for a walk, or the held entry for a put.
                mem_rd_en   = start;
                mem_rd_addr = (i_req.operation == ntab_pkg::OP_PUT)
                              ? ntab_pkg::IDX_W'(i_req.held_entry) : '0;
            end
            S_SCAN: begin
                // Keep the walk going one entry ahead of the compare.
                mem_rd_en   = (r_cmp_idx != LAST_IDX);
                mem_rd_addr = r_cmp_idx + 1'b1;
                if (cur_match) begin
                    mem_wr_en         = 1'b1;
                    mem_wr_addr       = r_cmp_idx;
                    mem_wr_data       = r_rd_data;
                    if (r_rd_data.users != ntab_pkg::COUNT_MAX) begin
                        mem_wr_data.users = r_rd_data.users + 1'b1;
                    end
                end else if (r_cmp_idx == LAST_IDX && claim_ok) begin
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = claim_idx;
                    mem_wr_data.key    = r_req.base_value[ntab_pkg::KEY_W-1:1];
                    mem_wr_data.nested = r_req.nested_enable;
                    mem_wr_data.users  = ntab_pkg::USER_COUNT_BITS'(1);
                end
            end
            S_PUT: begin
                // Drop one user from a used entry that still has any.
                mem_wr_addr       = held_idx;
                mem_wr_data       = r_rd_data;
                mem_wr_data.users = r_rd_data.users - 1'b1;
                mem_wr_en         = r_valid[held_idx] && (r_rd_data.users != '0);
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rd_data <= mem[mem_rd_addr];
        end
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmid_width <= ntab_pkg::VMID_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_vmid_width <= i_cfg_wdata;
        end
    end

    // Sequencer: state, request hold, walk bookkeeping and the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_done       <= 1'b0;
            r_free_found <= 1'b0;
            r_cmp_idx    <= '0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req        <= i_req;
                        r_cmp_idx    <= '0;
                        r_free_found <= 1'b0;
                        if (i_req.operation == ntab_pkg::OP_PUT) begin
                            r_result <= '0;
                            // Host or out-of-range put stays idle.
                            if (put_in_range) begin
                                r_state <= S_PUT;
                            end
                        end else if (i_req.hyp_context) begin
                            r_result <= '{entry_index: ntab_pkg::HOST_INDEX, hit: 1'b0,
                                          cleanup_needed: 1'b0, table_full: 1'b0};
                        end else begin
                            r_result <= '0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (cur_match) begin
                        r_result.entry_index <= 4'(r_cmp_idx);
                        r_result.hit         <= 1'b1;
                        r_state              <= S_IDLE;
                    end else if (r_cmp_idx == LAST_IDX) begin
                        if (claim_ok) begin
                            r_valid[claim_idx]      <= 1'b1;
                            r_result.entry_index    <= 4'(claim_idx);
                            r_result.cleanup_needed <= claim_clean;
                        end else begin
                            r_result.table_full <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        // Hold the first free entry seen; keep looking for a hit.
                        if (!r_free_found && cur_free) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_cmp_idx;
                            r_free_clean <= cur_valid;
                        end
                        r_cmp_idx <= r_cmp_idx + 1'b1;
                    end
                end
                S_PUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/ntab_checker.sv -----
// ----------------------------------------------------------------------------
// ntab_checker
// Port-level checks of the nested context table, bound to the top level.
// ----------------------------------------------------------------------------
module ntab_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  ntab_pkg::t_req                  i_req,
    input  logic                            o_done,
    input  ntab_pkg::t_rsp                  o_result
);

    logic accept;
    assign accept = start && !busy;

    // A load from hypervisor context gets the host entry on the next cycle.
    a_host_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.operation == ntab_pkg::OP_LOAD) && i_req.hyp_context |=>
        o_done && (o_result.entry_index == ntab_pkg::HOST_INDEX) &&
        !o_result.hit && !o_result.table_full)
        else $error("host load did not return the host entry");

    // A put of the host or beyond the table answers at once with all zeros.
    a_host_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.operation == ntab_pkg::OP_PUT) &&
        (i_req.held_entry >= ntab_pkg::HOST_INDEX) |=>
        o_done && (o_result == '0))
        else $error("put of host entry gave a nonzero result");

    // A full table changes nothing and points at entry zero.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.table_full |->
        (o_result.entry_index == '0) && !o_result.hit && !o_result.cleanup_needed)
        else $error("table full result carries other flags");

    // The block is idle again when it delivers a result.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result delivered while still busy");

    // A hit never also claims an entry.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit |-> !o_result.cleanup_needed &&
        (o_result.entry_index < ntab_pkg::HOST_INDEX))
        else $error("hit result is malformed");

endmodule

bind nested_context_table ntab_checker u_ntab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_done      (o_done),
    .o_result    (o_result)
);
